/* design/ofq_pkg.sv */
// ----------------------------------------------------------------------------
// ofq_pkg
// Shared types and codes for the overcurrent fault qualifier: event codes,
// result codes, configuration register indexes and the structs between blocks.
// ----------------------------------------------------------------------------
package ofq_pkg;

    localparam int unsigned CurrentWidth = 16;
    localparam int unsigned TimeWidth    = 16;
    localparam int unsigned CountWidth   = 8;
    localparam int unsigned CfgIdxWidth  = 2;
    localparam int unsigned CfgDataWidth = 16;

    typedef logic [CurrentWidth-1:0] ofq_current_t;
    typedef logic [TimeWidth-1:0]    ofq_time_t;
    typedef logic [CountWidth-1:0]   ofq_count_t;

    typedef enum logic [1:0] {
        OP_CHECK       = 2'd0,
        OP_TICK        = 2'd1,
        OP_CLR_FAULT   = 2'd2,
        OP_CLR_REPEAT  = 2'd3
    } ofq_op_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_DETECT = 2'd1,
        EV_LATCH  = 2'd2
    } ofq_event_t;

    localparam logic [CfgIdxWidth-1:0] CFG_CURRENT_LIMIT = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_NOISE_TIME    = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_REPEAT_LIMIT  = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_WINDOW_TIME   = 2'd3;

    localparam ofq_current_t RST_CURRENT_LIMIT = 16'd10000;
    localparam ofq_time_t    RST_NOISE_TIME    = 16'd100;
    localparam ofq_count_t   RST_REPEAT_LIMIT  = 8'd3;
    localparam ofq_time_t    RST_WINDOW_TIME   = 16'd1000;

    typedef struct packed {
        ofq_current_t current_limit;
        ofq_time_t    noise_time;
        ofq_count_t   repeat_limit;
        ofq_time_t    window_time;
    } ofq_cfg_t;

    typedef struct packed {
        ofq_op_t      operation;
        ofq_current_t current_sample;
        logic         motion_paused;
    } ofq_item_t;

    typedef struct packed {
        logic       fault;
        ofq_count_t repeat_count;
        ofq_event_t event_res;
    } ofq_res_t;

endpackage

/* design/ofq_item_if.sv */
// ----------------------------------------------------------------------------
// ofq_item_if
// Input channel: one event beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ofq_item_if
    import ofq_pkg::*;
();
    logic         valid;
    logic         ready;
    logic [1:0]   operation;
    ofq_current_t current_sample;
    logic         motion_paused;

    modport source (output valid, output operation, output current_sample,
                    output motion_paused, input ready);
    modport sink   (input valid, input operation, input current_sample,
                    input motion_paused, output ready);
endinterface

/* design/ofq_result_if.sv */
// ----------------------------------------------------------------------------
// ofq_result_if
// Output channel: one result beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ofq_result_if
    import ofq_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       fault;
    ofq_count_t repeat_count;
    logic [1:0] event_res;

    modport source (output valid, output fault, output repeat_count,
                    output event_res, input ready);
    modport sink   (input valid, input fault, input repeat_count,
                    input event_res, output ready);
endinterface

/* design/ofq_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ofq_cfg_regs
// Configuration register file: limit, noise time, repeat limit, window time.
// ----------------------------------------------------------------------------
module ofq_cfg_regs
    import ofq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_wdata,
    output ofq_cfg_t                cfg
);

    ofq_cfg_t cfg_reg;
    ofq_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CURRENT_LIMIT: cfg_next.current_limit = cfg_wdata;
                CFG_NOISE_TIME:    cfg_next.noise_time    = cfg_wdata;
                CFG_REPEAT_LIMIT:  cfg_next.repeat_limit  = cfg_wdata[CountWidth-1:0];
                CFG_WINDOW_TIME:   cfg_next.window_time   = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.current_limit <= RST_CURRENT_LIMIT;
            cfg_reg.noise_time    <= RST_NOISE_TIME;
            cfg_reg.repeat_limit  <= RST_REPEAT_LIMIT;
            cfg_reg.window_time   <= RST_WINDOW_TIME;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/ofq_core.sv */
// ----------------------------------------------------------------------------
// ofq_core
// Qualifier state and its single-pass update: noise timer, window timer,
// detection count and fault latch. Produces the result of the current beat.
// ----------------------------------------------------------------------------
module ofq_core
    import ofq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  ofq_item_t item,
    input  ofq_cfg_t  cfg,
    output ofq_res_t  res_next
);

    typedef struct packed {
        ofq_time_t  noise_timer;
        logic       noise_running;
        logic       noise_expired;
        ofq_time_t  window_timer;
        logic       window_expired;
        ofq_count_t detect_count;
        logic       fault_latch;
    } ofq_state_t;

    ofq_state_t st_reg;
    ofq_state_t st_next;
    ofq_event_t ev;
    ofq_count_t count_inc;
    ofq_time_t  noise_dec;
    ofq_time_t  window_dec;
    logic       over;

    assign over       = item.current_sample >= cfg.current_limit;
    assign count_inc  = st_reg.detect_count + ofq_count_t'(1);
    assign noise_dec  = st_reg.noise_timer - ofq_time_t'(1);
    assign window_dec = st_reg.window_timer - ofq_time_t'(1);

    always_comb
    begin
        st_next = st_reg;
        ev      = EV_NONE;
        unique case (item.operation)
            OP_CHECK:
            begin
                if (!item.motion_paused)
                begin
                    if (over)
                    begin
                        if (!st_reg.fault_latch)
                        begin
                            if (!st_reg.noise_running)
                            begin
                                if (cfg.noise_time == '0)
                                begin
                                    st_next.noise_expired = 1'b1;
                                    st_next.noise_timer   = '0;
                                end
                                else
                                begin
                                    st_next.noise_timer   = cfg.noise_time;
                                    st_next.noise_running = 1'b1;
                                    st_next.noise_expired = 1'b0;
                                end
                            end
                            else if (st_reg.noise_expired)
                            begin
                                st_next.noise_timer   = '0;
                                st_next.noise_running = 1'b0;
                                if (count_inc >= cfg.repeat_limit)
                                begin
                                    st_next.fault_latch  = 1'b1;
                                    st_next.detect_count = '0;
                                    st_next.window_timer = '0;
                                    ev                   = EV_LATCH;
                                end
                                else
                                begin
                                    st_next.detect_count = count_inc;
                                    if (cfg.window_time == '0)
                                    begin
                                        st_next.window_expired = 1'b1;
                                        st_next.window_timer   = '0;
                                    end
                                    else
                                    begin
                                        st_next.window_timer   = cfg.window_time;
                                        st_next.window_expired = 1'b0;
                                    end
                                    ev = EV_DETECT;
                                end
                            end
                        end
                    end
                    else
                    begin
                        st_next.noise_timer   = '0;
                        st_next.noise_running = 1'b0;
                    end
                    // expired window drops the repeat count
                    if (st_next.window_expired)
                    begin
                        st_next.noise_timer    = '0;
                        st_next.detect_count   = '0;
                        st_next.noise_running  = 1'b0;
                        st_next.window_timer   = '0;
                        st_next.window_expired = 1'b0;
                    end
                end
            end
            OP_TICK:
            begin
                if (st_reg.noise_timer != '0)
                begin
                    st_next.noise_timer   = noise_dec;
                    st_next.noise_expired = (noise_dec == '0);
                end
                if (st_reg.window_timer != '0)
                begin
                    st_next.window_timer   = window_dec;
                    st_next.window_expired = (window_dec == '0);
                end
            end
            OP_CLR_FAULT:
            begin
                st_next.fault_latch = 1'b0;
            end
            OP_CLR_REPEAT:
            begin
                st_next.noise_timer    = '0;
                st_next.detect_count   = '0;
                st_next.noise_running  = 1'b0;
                st_next.window_timer   = '0;
                st_next.window_expired = 1'b0;
            end
            default:
            begin
                st_next = st_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

    assign res_next.fault        = st_next.fault_latch;
    assign res_next.repeat_count = st_next.detect_count;
    assign res_next.event_res    = ev;

endmodule

/* design/overcurrent_fault_qualifier.sv */
// ----------------------------------------------------------------------------
// overcurrent_fault_qualifier
// Qualifies motor overcurrent checks and millisecond ticks into a latched fault.
//
//   channel  dir  handshake      beat contents
//   item     in   valid/ready    operation, current_sample, motion_paused
//   result   out  valid/ready    fault, repeat_count, event_res
//   cfg      in   cfg_we         cfg_index, cfg_wdata (no read-back)
//
// One beat per cycle sustained while results are taken; an item passes through
// the input register, then the state update and result register in one pass.
// A stalled result holds the result register and backs up into the input
// register; both free up in the same cycle the result is taken.
// Reset clears all qualifier state and loads the register defaults.
// ----------------------------------------------------------------------------
module overcurrent_fault_qualifier
    import ofq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    ofq_item_if.sink                item,
    ofq_result_if.source            result,
    input  logic                    cfg_we,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_wdata
);

    ofq_cfg_t  cfg;
    ofq_item_t item_reg;
    logic      item_vld_reg;
    ofq_res_t  res_reg;
    logic      res_vld_reg;
    ofq_res_t  res_next;
    logic      res_free;
    logic      fire;
    logic      take;

    assign res_free   = !res_vld_reg || result.ready;
    assign fire       = item_vld_reg && res_free;
    assign item.ready = !item_vld_reg || fire;
    assign take       = item.valid && item.ready;

    ofq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ofq_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (item_reg),
        .cfg      (cfg),
        .res_next (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                item_vld_reg <= item.valid;
            end
            if (res_free)
            begin
                res_vld_reg <= fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.operation      <= ofq_op_t'(item.operation);
            item_reg.current_sample <= item.current_sample;
            item_reg.motion_paused  <= item.motion_paused;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid        = res_vld_reg;
    assign result.fault        = res_reg.fault;
    assign result.repeat_count = res_reg.repeat_count;
    assign result.event_res    = res_reg.event_res;

    a_latch_sets_fault: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && res_reg.event_res == EV_LATCH |-> res_reg.fault
                                                      && res_reg.repeat_count == '0)
        else $error("latch event without fault or with nonzero count");

    a_detect_needs_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && res_reg.event_res == EV_DETECT |-> !res_reg.fault)
        else $error("detection reported while fault latched");

    a_clr_fault: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item_reg.operation == OP_CLR_FAULT |=> !res_reg.fault
                                                     && res_reg.event_res == EV_NONE)
        else $error("fault clear did not clear fault");

    a_clr_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item_reg.operation == OP_CLR_REPEAT |=> res_reg.repeat_count == '0)
        else $error("repeat clear left a nonzero count");

endmodule

/* bench/ofq_status_checker.sv */
// ----------------------------------------------------------------------------
// ofq_status_checker
// Watches the event, status and register write ports of the overcurrent fault
// qualifier. Keeps its own copy of the qualifier state and settings, works out
// the status beat each accepted event must produce and compares the status
// beats, oldest first, field by field. Hands the mismatch count and the number
// of status beats still owed to the testbench top.
// ----------------------------------------------------------------------------
module ofq_status_checker
    import ofq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    ofq_item_if                     item_mon,
    ofq_result_if                   result_mon,
    input  logic                    cfg_we,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_wdata,
    output int                      mismatch_total,
    output int                      status_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    ofq_current_t lim_current;
    ofq_time_t    lim_noise;
    ofq_count_t   lim_repeat;
    ofq_time_t    lim_window;

    ofq_time_t    noise_timer;
    logic         noise_running;
    logic         noise_expired;
    ofq_time_t    window_timer;
    logic         window_expired;
    ofq_count_t   detections;
    logic         fault_latched;

    ofq_res_t     owed_status_q[$];

    function automatic void drop_repeat_count();
        noise_timer    = '0;
        detections     = '0;
        noise_running  = 1'b0;
        window_timer   = '0;
        window_expired = 1'b0;
    endfunction

    function automatic ofq_res_t qualify_event(ofq_op_t op, ofq_current_t sample,
                                               logic paused);
        ofq_res_t   status;
        ofq_event_t ev;
        ev = EV_NONE;
        case (op)
            OP_CHECK:
            begin
                if (!paused)
                begin
                    if (sample >= lim_current)
                    begin
                        if (!fault_latched)
                        begin
                            if (!noise_running)
                            begin
                                if (lim_noise == '0)
                                begin
                                    noise_expired = 1'b1;
                                    noise_timer   = '0;
                                end
                                else
                                begin
                                    noise_timer   = lim_noise;
                                    noise_running = 1'b1;
                                    noise_expired = 1'b0;
                                end
                            end
                            else if (noise_expired)
                            begin
                                noise_timer   = '0;
                                noise_running = 1'b0;
                                detections    = detections + 8'd1;
                                if (detections >= lim_repeat)
                                begin
                                    fault_latched = 1'b1;
                                    detections    = '0;
                                    window_timer  = '0;
                                    ev            = EV_LATCH;
                                end
                                else
                                begin
                                    if (lim_window == '0)
                                    begin
                                        window_expired = 1'b1;
                                        window_timer   = '0;
                                    end
                                    else
                                    begin
                                        window_timer   = lim_window;
                                        window_expired = 1'b0;
                                    end
                                    ev = EV_DETECT;
                                end
                            end
                        end
                    end
                    else
                    begin
                        noise_timer   = '0;
                        noise_running = 1'b0;
                    end
                    if (window_expired)
                        drop_repeat_count();
                end
            end
            OP_TICK:
            begin
                if (noise_timer != '0)
                begin
                    noise_timer   = noise_timer - 16'd1;
                    noise_expired = (noise_timer == '0);
                end
                if (window_timer != '0)
                begin
                    window_timer   = window_timer - 16'd1;
                    window_expired = (window_timer == '0);
                end
            end
            OP_CLR_FAULT:
                fault_latched = 1'b0;
            default:
                drop_repeat_count();
        endcase
        status.fault        = fault_latched;
        status.repeat_count = detections;
        status.event_res    = ev;
        return status;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        ofq_res_t got;
        ofq_res_t want;
        if (!rst_n)
        begin
            lim_current    = RST_CURRENT_LIMIT;
            lim_noise      = RST_NOISE_TIME;
            lim_repeat     = RST_REPEAT_LIMIT;
            lim_window     = RST_WINDOW_TIME;
            noise_timer    = '0;
            noise_running  = 1'b0;
            noise_expired  = 1'b0;
            window_timer   = '0;
            window_expired = 1'b0;
            detections     = '0;
            fault_latched  = 1'b0;
            owed_status_q.delete();
            mismatch_total = 0;
            status_outstanding = 0;
        end
        else
        begin
            if (result_mon.valid && result_mon.ready)
            begin
                got.fault        = result_mon.fault;
                got.repeat_count = result_mon.repeat_count;
                got.event_res    = ofq_event_t'(result_mon.event_res);
                if (owed_status_q.size() == 0)
                begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("%0t: unexpected status beat fault=%0b count=%0d event=%0d",
                                 $realtime, got.fault, got.repeat_count, got.event_res);
                end
                else
                begin
                    want = owed_status_q.pop_front();
                    if (got.fault !== want.fault || got.repeat_count !== want.repeat_count
                        || got.event_res !== want.event_res)
                    begin
                        mismatch_total++;
                        if (mismatch_total <= 10)
                            $display({"%0t: status mismatch: expected fault=%0b count=%0d ",
                                      "event=%0d, got fault=%0b count=%0d event=%0d"},
                                     $realtime, want.fault, want.repeat_count,
                                     want.event_res, got.fault, got.repeat_count,
                                     got.event_res);
                    end
                end
            end
            if (item_mon.valid && item_mon.ready)
                owed_status_q.push_back(qualify_event(ofq_op_t'(item_mon.operation),
                                                      item_mon.current_sample,
                                                      item_mon.motion_paused));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CURRENT_LIMIT: lim_current = cfg_wdata;
                    CFG_NOISE_TIME:    lim_noise   = cfg_wdata;
                    CFG_REPEAT_LIMIT:  lim_repeat  = cfg_wdata[CountWidth-1:0];
                    CFG_WINDOW_TIME:   lim_window  = cfg_wdata;
                    default: ;
                endcase
            end
            status_outstanding = owed_status_q.size();
        end
    end

endmodule

/* bench/tb_overcurrent_fault_qualifier.sv */
// ----------------------------------------------------------------------------
// tb_overcurrent_fault_qualifier
// Drives the overcurrent fault qualifier with a short directed run at the
// register defaults and small settings, then with random overload episodes
// (over-limit check, noise ticks, qualifying check) mixed with random events,
// across several register settings including the extremes. The event sender
// works in bursts, the status receiver stalls on its own pattern and once holds
// off long enough to back the block up. The checker does all comparing.
// ----------------------------------------------------------------------------
module tb_overcurrent_fault_qualifier;
    import ofq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CfgIdxWidth-1:0]  cfg_index;
    logic [CfgDataWidth-1:0] cfg_wdata;
    int                      mismatch_total;
    int                      status_outstanding;

    ofq_current_t cur_limit;
    ofq_time_t    cur_noise;
    int           gap_max;
    int           burst_left;
    int           beats_sent;
    logic         backpressure_armed;

    ofq_item_if   item_bus ();
    ofq_result_if result_bus ();

    overcurrent_fault_qualifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ofq_status_checker status_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .item_mon           (item_bus),
        .result_mon         (result_bus),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .mismatch_total     (mismatch_total),
        .status_outstanding (status_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic ofq_current_t over_sample();
        if ($urandom_range(0, 3) == 0)
            return cur_limit;
        return ofq_current_t'(int'(cur_limit) + $urandom_range(0, 65535 - int'(cur_limit)));
    endfunction

    function automatic ofq_current_t under_sample();
        if (cur_limit == '0)
            return '0;
        if ($urandom_range(0, 3) == 0)
            return cur_limit - 16'd1;
        return ofq_current_t'($urandom_range(0, int'(cur_limit) - 1));
    endfunction

    // call at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(ofq_op_t op, ofq_current_t sample, logic paused);
        if (burst_left == 0)
        begin
            item_bus.valid = 1'b0;
            if (gap_max > 0)
                repeat ($urandom_range(0, gap_max)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        item_bus.valid          = 1'b1;
        item_bus.operation      = op;
        item_bus.current_sample = sample;
        item_bus.motion_paused  = paused;
        @(posedge clk iff item_bus.ready);
        @(negedge clk);
        burst_left--;
        beats_sent++;
    endtask

    task automatic wait_idle();
        item_bus.valid = 1'b0;
        while (status_outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
        cfg_index = idx;
        cfg_wdata = data;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic load_setting(ofq_current_t limit, ofq_time_t noise, ofq_count_t rep_lim,
                                ofq_time_t window);
        wait_idle();
        write_reg(CFG_CURRENT_LIMIT, limit);
        write_reg(CFG_NOISE_TIME, noise);
        write_reg(CFG_REPEAT_LIMIT, CfgDataWidth'(rep_lim));
        write_reg(CFG_WINDOW_TIME, window);
        cur_limit = limit;
        cur_noise = noise;
    endtask

    task automatic run_episodes(int budget);
        int target;
        int kind;
        int ticks;
        target = beats_sent + budget;
        while (beats_sent < target)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 12)
            begin
                send_beat(OP_CHECK, over_sample(), 1'b0);
                if (int'(cur_noise) > 6)
                    ticks = $urandom_range(1, 6);
                else
                    ticks = int'(cur_noise) - 1 + int'($urandom_range(0, 2));
                for (int i = 0; i < ticks; i++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_beat(OP_CHECK, over_sample(), $urandom_range(0, 1));
                    send_beat(OP_TICK, ofq_current_t'($urandom), $urandom_range(0, 1));
                end
                send_beat(OP_CHECK, over_sample(), $urandom_range(0, 5) == 0);
            end
            else if (kind < 14)
            begin
                repeat ($urandom_range(1, 6))
                    send_beat(OP_TICK, ofq_current_t'($urandom), $urandom_range(0, 1));
            end
            else if (kind < 16)
                send_beat(ofq_op_t'($urandom_range(0, 3)), ofq_current_t'($urandom),
                          $urandom_range(0, 1));
            else if (kind == 16)
                send_beat(OP_CHECK, under_sample(), $urandom_range(0, 1));
            else if (kind < 19)
                send_beat(OP_CLR_FAULT, ofq_current_t'($urandom), $urandom_range(0, 1));
            else
                send_beat(OP_CLR_REPEAT, ofq_current_t'($urandom), $urandom_range(0, 1));
        end
    endtask

    initial
    begin
        int cyc;
        int hold_at;
        result_bus.ready = 1'b0;
        cyc     = 0;
        hold_at = -1;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (backpressure_armed && hold_at < 0)
                hold_at = cyc + 20;
            if (hold_at >= 0 && cyc >= hold_at && cyc < hold_at + 80)
                result_bus.ready = 1'b0;
            else
            begin
                case ((cyc / 97) % 4)
                    0:       result_bus.ready = 1'b1;
                    1:       result_bus.ready = $urandom_range(0, 1);
                    2:       result_bus.ready = (cyc % 3) != 0;
                    default: result_bus.ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = CFG_CURRENT_LIMIT;
        cfg_wdata               = '0;
        item_bus.valid          = 1'b0;
        item_bus.operation      = OP_CHECK;
        item_bus.current_sample = '0;
        item_bus.motion_paused  = 1'b0;
        cur_limit               = RST_CURRENT_LIMIT;
        cur_noise               = RST_NOISE_TIME;
        gap_max                 = 3;
        burst_left              = 0;
        beats_sent              = 0;
        backpressure_armed      = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_beat(OP_CHECK, 16'd0, 1'b0);
        send_beat(OP_CHECK, 16'hFFFF, 1'b1);
        send_beat(OP_CHECK, 16'd9999, 1'b0);
        send_beat(OP_CHECK, 16'd10000, 1'b0);
        send_beat(OP_TICK, 16'd0, 1'b0);
        send_beat(OP_CLR_REPEAT, 16'd0, 1'b0);
        send_beat(OP_CLR_FAULT, 16'd0, 1'b0);
        send_beat(OP_CHECK, 16'hFFFF, 1'b0);

        // zero window: detection clears the count at once
        load_setting(16'd100, 16'd1, 8'd2, 16'd0);
        send_beat(OP_CHECK, 16'd100, 1'b0);
        send_beat(OP_TICK, 16'd0, 1'b0);
        send_beat(OP_CHECK, 16'd100, 1'b0);

        wait_idle();
        write_reg(CFG_WINDOW_TIME, 16'd2);
        send_beat(OP_CHECK, 16'd100, 1'b0);
        send_beat(OP_TICK, 16'd0, 1'b0);
        send_beat(OP_CHECK, 16'hFFFF, 1'b0);
        send_beat(OP_CHECK, 16'd100, 1'b0);
        send_beat(OP_TICK, 16'd0, 1'b0);
        send_beat(OP_CHECK, 16'd100, 1'b0);
        send_beat(OP_CHECK, 16'd200, 1'b0);
        send_beat(OP_TICK, 16'd0, 1'b0);
        send_beat(OP_CLR_FAULT, 16'd0, 1'b0);
        send_beat(OP_CHECK, 16'd50, 1'b0);

        load_setting(16'd5000, 16'd1, 8'd1, 16'd0);
        gap_max = 2;
        backpressure_armed = 1'b1;
        run_episodes(140);
        load_setting(16'd1000, 16'd2, 8'd3, 16'd5);
        gap_max = 0;
        run_episodes(160);
        load_setting(16'd0, 16'd3, 8'd2, 16'hFFFF);
        gap_max = 6;
        run_episodes(150);
        load_setting(16'hFFFF, 16'd1, 8'd4, 16'd3);
        gap_max = 3;
        run_episodes(130);
        load_setting(16'd30000, 16'd0, 8'd2, 16'd10);
        gap_max = 1;
        run_episodes(120);
        load_setting(16'd20000, 16'd2, 8'd0, 16'd4);
        gap_max = 0;
        run_episodes(150);
        load_setting(16'd40000, 16'hFFFF, 8'd255, 16'd1);
        gap_max = 4;
        run_episodes(100);
        load_setting(16'd1234, 16'd4, 8'd5, 16'd20);
        gap_max = 2;
        run_episodes(150);

        item_bus.valid = 1'b0;
        while (status_outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatch_total == 0 && status_outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
design/ofq_pkg.sv
design/ofq_item_if.sv
design/ofq_result_if.sv
design/ofq_cfg_regs.sv
design/ofq_core.sv
design/overcurrent_fault_qualifier.sv
bench/ofq_status_checker.sv
bench/tb_overcurrent_fault_qualifier.sv
